// ----- rtl/cra_pkg.sv -----
package cra_pkg;

  localparam logic [1:0] ST_GRANT    = 2'd0;
  localparam logic [1:0] ST_NONE     = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic REG_CHUNKS_IN_USE = 1'b0;
  localparam logic REG_PROTECT_LIMIT = 1'b1;

  localparam logic [8:0] CHUNKS_IN_USE_RESET = 9'd256;
  localparam logic [8:0] PROTECT_LIMIT_RESET = 9'd4;

endpackage

// ----- rtl/cra_mem.sv -----
module cra_mem #(
  parameter int W  = 8,
  parameter int D  = 16,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/chunk_recycling_allocator_unit.sv -----
// Channel   Dir  Bits  Contents
// s_axis    in   8     tdata: thread_slot[5:0]
// m_axis    out  48    tdata: status[1:0], chunk_id[9:2], generation[41:10]
// cfg       in   9     cfg_index 0 chunks_in_use, 1 protect_limit
//
// After reset a clearing pass writes every chunk and thread entry, with s_axis_tready low.
// The chunk memory's single read port scans one entry per cycle; a never-used chunk ends
// the scan early. A grant passes S_DECIDE, S_RD_NEW and S_WR_NEW when the list tail is
// linked, S_CHK_EXP, S_WR_EXP when the head expires, S_WR_THR and S_RESULT; a refusal
// goes straight to S_RESULT. A request is taken only in S_IDLE, once the last result is
// registered. A result waiting in the output register stalls only the next result.
module chunk_recycling_allocator_unit #(
  parameter int CHUNKS  = 256,
  parameter int THREADS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // thread_slot[5:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // status[1:0], chunk_id[9:2], generation[41:10]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int AW   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int CW   = $clog2(CHUNKS + 1);
  localparam int CNTW = CW + 1;
  localparam int TAW  = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int TCW  = $clog2(THREADS + 1);
  localparam int SXW  = (TCW > 6) ? TCW : 6;
  localparam int EW   = (CW > 9) ? CW : 9;
  localparam int LW   = (CNTW > 9) ? CNTW : 9;
  localparam int DMAX = (CHUNKS > THREADS) ? CHUNKS : THREADS;
  localparam int DW   = $clog2(DMAX + 1);
  localparam logic [CW-1:0] NO_CHUNK = CW'(CHUNKS);

  typedef struct packed {
    logic          used;
    logic          prot;
    logic [63:0]   epoch;
    logic [31:0]   gen;
    logic [CW-1:0] nxt;
  } chunk_t;

  typedef struct packed {
    logic [CW-1:0]   newest;
    logic [CW-1:0]   oldest;
    logic [CNTW-1:0] cnt;
  } thread_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_DECIDE, S_RD_NEW, S_WR_NEW,
    S_CHK_EXP, S_WR_EXP, S_WR_THR, S_RESULT
  } state_t;

  state_t state;

  logic [8:0] chunks_in_use;
  logic [8:0] protect_limit;

  logic [DW-1:0]  clr;
  logic [TAW-1:0] slot;
  logic [CW-1:0]  count;
  logic [CW-1:0]  scan_addr;
  logic           rv;
  logic [CW-1:0]  ridx;
  logic [CW-1:0]  sel;
  logic           sel_ok;
  logic [31:0]    sel_gen;
  logic [63:0]    best;
  logic [63:0]    epoch_counter;
  logic [CW-1:0]  p_new;
  logic [CW-1:0]  t_new;
  logic [CW-1:0]  t_old;
  logic [CNTW-1:0] t_cnt;
  logic [1:0]     res_status;

  logic           c_we, c_re, t_we, t_re;
  logic [AW-1:0]  c_waddr, c_raddr;
  logic [TAW-1:0] t_waddr, t_raddr;
  chunk_t         c_wdata, c_rdata;
  thread_t        t_wdata, t_rdata;

  logic [SXW-1:0] slot_x;
  logic [EW-1:0]  count_x;
  logic [CW-1:0]  count_eff;
  logic [8:0]     limit;
  logic           grant;
  logic           expire;

  cra_mem #(.W($bits(chunk_t)), .D(CHUNKS), .AW(AW)) u_chunk_mem (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .re(c_re), .raddr(c_raddr), .rdata(c_rdata)
  );

  cra_mem #(.W($bits(thread_t)), .D(THREADS), .AW(TAW)) u_thread_mem (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .re(t_re), .raddr(t_raddr), .rdata(t_rdata)
  );

  assign slot_x    = SXW'(s_axis_tdata[5:0]);
  assign count_x   = EW'(chunks_in_use);
  assign count_eff = (count_x > EW'(CHUNKS)) ? NO_CHUNK : CW'(count_x);
  assign limit     = (protect_limit == 9'd0) ? 9'd1 : protect_limit;
  assign grant     = sel_ok && (sel_gen != 32'hFFFF_FFFF) && (epoch_counter != 64'hFFFF_FFFF_FFFF_FFFF);
  assign expire    = (LW'(t_cnt) > LW'(limit)) && (t_old < NO_CHUNK);

  assign s_axis_tready = (state == S_IDLE);

  always_comb begin
    c_we    = 1'b0;
    c_waddr = sel[AW-1:0];
    c_wdata = c_rdata;
    c_re    = 1'b0;
    c_raddr = scan_addr[AW-1:0];
    t_we    = 1'b0;
    t_waddr = slot;
    t_wdata = '{newest: t_new, oldest: t_old, cnt: t_cnt};
    t_re    = 1'b0;
    t_raddr = slot_x[TAW-1:0];
    unique case (state)
      S_CLEAR: begin
        c_we    = (clr < DW'(CHUNKS));
        c_waddr = clr[AW-1:0];
        c_wdata = '{used: 1'b0, prot: 1'b0, epoch: 64'd0, gen: 32'd0, nxt: NO_CHUNK};
        t_we    = (clr < DW'(THREADS));
        t_waddr = clr[TAW-1:0];
        t_wdata = '{newest: NO_CHUNK, oldest: NO_CHUNK, cnt: '0};
      end
      S_IDLE: begin
        t_re = s_axis_tvalid;
      end
      S_SCAN: begin
        c_re = (scan_addr < count);
      end
      S_DECIDE: begin
        c_we    = grant;
        c_wdata = '{used: 1'b1, prot: 1'b1, epoch: epoch_counter + 64'd1,
                    gen: sel_gen + 32'd1, nxt: NO_CHUNK};
      end
      S_RD_NEW: begin
        c_re    = 1'b1;
        c_raddr = p_new[AW-1:0];
      end
      S_WR_NEW: begin
        c_we     = 1'b1;
        c_waddr  = p_new[AW-1:0];
        c_wdata.nxt = sel;
      end
      S_CHK_EXP: begin
        c_re    = expire;
        c_raddr = t_old[AW-1:0];
      end
      S_WR_EXP: begin
        c_we      = 1'b1;
        c_waddr   = t_old[AW-1:0];
        c_wdata.prot = 1'b0;
      end
      S_WR_THR: begin
        t_we = 1'b1;
      end
      S_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr           <= '0;
      chunks_in_use <= cra_pkg::CHUNKS_IN_USE_RESET;
      protect_limit <= cra_pkg::PROTECT_LIMIT_RESET;
      epoch_counter <= 64'd0;
      m_axis_tvalid <= 1'b0;
      rv            <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          cra_pkg::REG_CHUNKS_IN_USE: chunks_in_use <= cfg_data;
          cra_pkg::REG_PROTECT_LIMIT: protect_limit <= cfg_data;
          default: ;
        endcase
      end
      if (state == S_RESULT && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      rv <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr <= clr + DW'(1);
          if (clr == DW'(DMAX - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            slot      <= slot_x[TAW-1:0];
            count     <= count_eff;
            scan_addr <= '0;
            sel       <= NO_CHUNK;
            sel_ok    <= 1'b0;
            sel_gen   <= 32'd0;
            best      <= 64'hFFFF_FFFF_FFFF_FFFF;
            if (slot_x >= SXW'(THREADS)) begin
              res_status <= cra_pkg::ST_NONE;
              state      <= S_RESULT;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_addr < count) begin
            rv        <= 1'b1;
            ridx      <= scan_addr;
            scan_addr <= scan_addr + CW'(1);
          end
          if (rv && !c_rdata.used) begin
            // a never-used chunk wins outright; drop the read in flight
            sel     <= ridx;
            sel_ok  <= 1'b1;
            sel_gen <= c_rdata.gen;
            state   <= S_DECIDE;
          end else begin
            if (rv && !c_rdata.prot && (c_rdata.epoch < best)) begin
              sel     <= ridx;
              sel_ok  <= 1'b1;
              sel_gen <= c_rdata.gen;
              best    <= c_rdata.epoch;
            end
            if (!rv && (scan_addr == count)) begin
              state <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          if (!sel_ok) begin
            res_status <= cra_pkg::ST_NONE;
            state      <= S_RESULT;
          end else if (!grant) begin
            res_status <= cra_pkg::ST_OVERFLOW;
            state      <= S_RESULT;
          end else begin
            res_status    <= cra_pkg::ST_GRANT;
            sel_gen       <= sel_gen + 32'd1;
            epoch_counter <= epoch_counter + 64'd1;
            p_new         <= t_rdata.newest;
            t_new         <= sel;
            t_old         <= (t_rdata.newest < NO_CHUNK) ? t_rdata.oldest : sel;
            t_cnt         <= t_rdata.cnt + CNTW'(1);
            state         <= (t_rdata.newest < NO_CHUNK) ? S_RD_NEW : S_CHK_EXP;
          end
        end
        S_RD_NEW: begin
          state <= S_WR_NEW;
        end
        S_WR_NEW: begin
          state <= S_CHK_EXP;
        end
        S_CHK_EXP: begin
          state <= expire ? S_WR_EXP : S_WR_THR;
        end
        S_WR_EXP: begin
          // advance the list head past the expired chunk
          t_old <= c_rdata.nxt;
          t_cnt <= t_cnt - CNTW'(1);
          if (!(c_rdata.nxt < NO_CHUNK)) begin
            t_new <= NO_CHUNK;
          end
          state <= S_WR_THR;
        end
        S_WR_THR: begin
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESULT && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata[1:0]   <= res_status;
      m_axis_tdata[9:2]   <= (res_status == cra_pkg::ST_GRANT) ? 8'(sel) : 8'd0;
      m_axis_tdata[41:10] <= (res_status == cra_pkg::ST_GRANT) ? sel_gen : 32'd0;
      m_axis_tdata[47:42] <= 6'd0;
    end
  end

endmodule

// ----- dv/chunk_recycling_allocator_unit_tb.sv -----
`timescale 1ns / 100ps

module chunk_recycling_allocator_unit_tb;

  localparam int NCHUNK = 256;
  localparam int NTHREAD = 64;
  localparam logic [8:0] NO_ENTRY = 9'd256;
  localparam int STALL_LIMIT = 20000;
  localparam int LONG_HOLD = 3000;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  chunk_id;
    logic [31:0] generation;
  } grant_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // thread_slot[5:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // status[1:0], chunk_id[9:2], generation[41:10]
  logic        cfg_we = 1'b0;
  logic        cfg_index = cra_pkg::REG_CHUNKS_IN_USE;
  logic [8:0]  cfg_data = '0;

  chunk_recycling_allocator_unit dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // allocator state mirror
  logic        mir_used [NCHUNK];
  logic        mir_prot [NCHUNK];
  logic [63:0] mir_epoch [NCHUNK];
  logic [31:0] mir_gen [NCHUNK];
  logic [8:0]  mir_next [NCHUNK];
  logic [8:0]  mir_newest [NTHREAD];
  logic [8:0]  mir_oldest [NTHREAD];
  logic [8:0]  mir_pcount [NTHREAD];
  logic [63:0] mir_epoch_ctr;
  logic [8:0]  mir_chunks = cra_pkg::CHUNKS_IN_USE_RESET;
  logic [8:0]  mir_limit = cra_pkg::PROTECT_LIMIT_RESET;

  logic [5:0] pending_slots [$];
  grant_t     expected_grants [$];
  int         errors = 0;
  int         hold_req = 0;
  int         hold_seen = 0;
  bit         in_taken = 0;
  bit         send_pause = 0;
  int         gap_cnt = 0;
  int         stall_cnt = 0;
  int         quiet_cycles = 0;

  initial begin
    for (int i = 0; i < NCHUNK; i++) begin
      mir_used[i] = 0; mir_prot[i] = 0; mir_epoch[i] = '0; mir_gen[i] = '0;
      mir_next[i] = NO_ENTRY;
    end
    for (int t = 0; t < NTHREAD; t++) begin
      mir_newest[t] = NO_ENTRY; mir_oldest[t] = NO_ENTRY; mir_pcount[t] = '0;
    end
    mir_epoch_ctr = '0;
  end

  function automatic grant_t allocate_chunk(logic [5:0] slot);
    grant_t r;
    int count, limit, sel;
    logic [63:0] best;
    logic [8:0] expired;
    r = '0;
    count = (mir_chunks > NCHUNK) ? NCHUNK : mir_chunks;
    limit = (mir_limit == 0) ? 1 : mir_limit;
    sel = NCHUNK;
    best = '1;
    for (int i = 0; i < count; i++) begin
      if (!mir_used[i]) begin
        sel = i;
        break;
      end
      if (!mir_prot[i] && mir_epoch[i] < best) begin
        sel = i;
        best = mir_epoch[i];
      end
    end
    if (sel >= NCHUNK) begin
      r.status = cra_pkg::ST_NONE;
      return r;
    end
    if (mir_gen[sel] == '1 || mir_epoch_ctr == '1) begin
      r.status = cra_pkg::ST_OVERFLOW;
      return r;
    end
    mir_gen[sel] = mir_gen[sel] + 32'd1;
    mir_used[sel] = 1;
    mir_epoch_ctr = mir_epoch_ctr + 64'd1;
    mir_epoch[sel] = mir_epoch_ctr;
    mir_next[sel] = NO_ENTRY;
    mir_prot[sel] = 1;
    if (mir_newest[slot] < NCHUNK) mir_next[mir_newest[slot]] = 9'(sel);
    else mir_oldest[slot] = 9'(sel);
    mir_newest[slot] = 9'(sel);
    mir_pcount[slot] = mir_pcount[slot] + 9'd1;
    if (mir_pcount[slot] > limit) begin
      expired = mir_oldest[slot];
      // skip the expiry on an empty list head
      if (expired < NCHUNK) begin
        mir_oldest[slot] = mir_next[expired];
        mir_prot[expired] = 0;
        mir_pcount[slot] = mir_pcount[slot] - 9'd1;
        if (mir_oldest[slot] >= NCHUNK) mir_newest[slot] = NO_ENTRY;
      end
    end
    r.status = cra_pkg::ST_GRANT;
    r.chunk_id = sel[7:0];
    r.generation = mir_gen[sel];
    return r;
  endfunction

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      in_taken = 0;
      if (gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_slots.size() > 0 &&
                   !(send_pause && expected_grants.size() > 0)) begin
        s_axis_tdata <= {2'b00, pending_slots.pop_front()};
        s_axis_tvalid <= 1'b1;
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5: gap_cnt <= $urandom_range(1, 3);
          6: gap_cnt <= $urandom_range(20, 80);
          default: gap_cnt <= 0;
        endcase
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      stall_cnt = LONG_HOLD;
    end
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt = stall_cnt - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: stall_cnt = $urandom_range(1, 4);
        5: stall_cnt = $urandom_range(20, 100);
        default: stall_cnt = 0;
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    grant_t got, want;
    bit moved;
    moved = 0;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      in_taken = 1;
      moved = 1;
      expected_grants.push_back(allocate_chunk(s_axis_tdata[5:0]));
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      moved = 1;
      got.status = m_axis_tdata[1:0];
      got.chunk_id = m_axis_tdata[9:2];
      got.generation = m_axis_tdata[41:10];
      if (expected_grants.size() == 0) begin
        $error("unexpected result transaction: %h", m_axis_tdata);
        errors++;
      end else begin
        want = expected_grants.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          errors++;
        end
        if (got.chunk_id !== want.chunk_id) begin
          $error("chunk_id: expected %0d, got %0d", want.chunk_id, got.chunk_id);
          errors++;
        end
        if (got.generation !== want.generation) begin
          $error("generation: expected %0d, got %0d", want.generation, got.generation);
          errors++;
        end
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("chunk_recycling_allocator_unit_tb: errors");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [8:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == cra_pkg::REG_CHUNKS_IN_USE) mir_chunks = val;
    else mir_limit = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // drain all requests and results, then let the block settle
  task automatic drain;
    while (pending_slots.size() > 0 || s_axis_tvalid || expected_grants.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic run_phase(logic [8:0] chunks, logic [8:0] limit, int n, int slot_hi);
    drain();
    write_reg(cra_pkg::REG_CHUNKS_IN_USE, chunks);
    write_reg(cra_pkg::REG_PROTECT_LIMIT, limit);
    for (int k = 0; k < n; k++) pending_slots.push_back(6'($urandom_range(0, slot_hi)));
  endtask

  initial begin
    int issued;
    int n;
    logic [8:0] c, l;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings, both slot extremes and alternating bits
    pending_slots = '{6'd0, 6'd63, 6'h2a, 6'h15, 6'd0, 6'd0};
    // count of one with a wide limit: the only chunk stays pinned
    run_phase(9'd1, 9'd511, 3, 63);
    // no chunks at all
    run_phase(9'd0, 9'd0, 2, 63);
    // count above the chunk total saturates
    run_phase(9'd511, 9'd1, 3, 1);
    // grow one thread's list, then cut the limit below its length
    run_phase(9'd12, 9'd8, 8, 0);
    run_phase(9'd12, 9'd1, 5, 0);
    // fill the output while requests keep coming
    drain();
    hold_req++;
    for (int k = 0; k < 6; k++) pending_slots.push_back(6'($urandom_range(0, 3)));
    drain();
    // sender waits for every result before going on
    send_pause = 1;
    for (int k = 0; k < 6; k++) pending_slots.push_back(6'($urandom_range(0, 3)));
    drain();
    send_pause = 0;

    issued = 39;
    while (issued < 1130) begin
      case ($urandom_range(0, 19))
        0: c = 9'd0;
        1: c = 9'($urandom_range(257, 511));
        2: c = 9'd256;
        default: c = 9'($urandom_range(1, 24));
      endcase
      case ($urandom_range(0, 9))
        0: l = 9'd256;
        1: l = 9'($urandom_range(257, 511));
        default: l = 9'($urandom_range(0, 6));
      endcase
      n = (c >= 64) ? $urandom_range(5, 12) : $urandom_range(30, 60);
      run_phase(c, l, n, ($urandom_range(0, 3) == 0) ? 63 : 3);
      issued += n;
    end
    drain();

    if (errors == 0) begin
      $display("chunk_recycling_allocator_unit_tb: clean");
    end else begin
      $display("chunk_recycling_allocator_unit_tb: errors");
    end
    $finish;
  end

endmodule
